// ----- design/bpfa_pkg.sv -----
// Shared constants of the bitmap page-frame allocator: field widths, request
// modes, result status codes and configuration register indexes.
// No dependencies.
package bpfa_pkg;

  localparam int ADDR_W = 48;  // physical address and byte length
  localparam int CNT_W  = 17;  // page counts and page indexes
  localparam int MODE_W = 3;
  localparam int STAT_W = 2;
  localparam int WORD_W = 64;  // pages per bitmap word

  localparam int IN_W  = 104;  // mode, addr, length, padded to bytes
  localparam int OUT_W = 88;   // status, page_addr, is_reserved, counts, padded

  // request modes
  localparam logic [MODE_W-1:0] MODE_ALLOC   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_FREE    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_RESERVE = 3'd2;
  localparam logic [MODE_W-1:0] MODE_QUERY   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CLEAR   = 3'd4;

  // result status
  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NOFREE  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_INVALID = 2'd2;
  localparam logic [STAT_W-1:0] STAT_IGNORED = 2'd3;

  // configuration register indexes
  localparam logic REG_BASE_ADDR  = 1'b0;
  localparam logic REG_PAGE_COUNT = 1'b1;

endpackage

// ----- design/bpfa_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module bpfa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/bitmap_page_frame_allocator.sv -----
// Bitmap page-frame allocator, first fit. One used bit per managed page lives
// in a RAM of MAX_FRAMES/64 words of 64 bits; a small sequencer walks it one
// word at a time. An allocate request reads words from the first one up to
// the first word with a free page; free and query read the one word that holds
// the page; reserve reads and rewrites each bitmap word the range touches; clear
// writes every word. The bitmap RAM port moves one word per access.
// After reset the block sweeps every RAM word to zero and takes no request
// meanwhile; configuration writes are taken at any time.
// PAGE_BYTES must be a power of two. Results sit in an output register, so a
// new request is taken while the previous result still waits.
// Depends on bpfa_pkg and bpfa_ram.
module bitmap_page_frame_allocator #(
  parameter int MAX_FRAMES = 65536,
  parameter int PAGE_BYTES = 4096
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration: 0 base_addr, 1 page_count
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [bpfa_pkg::ADDR_W-1:0] cfg_wdata_i,
  // requests
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [bpfa_pkg::IN_W-1:0]   s_axis_tdata,  // mode[2:0], addr[50:3], length[98:51]
  // results
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [bpfa_pkg::OUT_W-1:0]  m_axis_tdata   // status[1:0], page_addr[49:2],
                                                     // is_reserved[50], free_count[67:51],
                                                     // used_count[84:68]
);
  import bpfa_pkg::*;

  localparam int PB_SH     = $clog2(PAGE_BYTES);
  localparam int PN_W      = ADDR_W - PB_SH;
  localparam int MAP_WORDS = (MAX_FRAMES + WORD_W - 1) / WORD_W;
  localparam int WA_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int MF_W      = $clog2(MAX_FRAMES + 1);
  localparam int CMP_W     = (MF_W > CNT_W) ? MF_W : CNT_W;
  localparam logic [ADDR_W-1:0] OFF_MASK = ADDR_W'(PAGE_BYTES - 1);
  localparam logic [WA_W-1:0]   LAST_WA  = WA_W'(MAP_WORDS - 1);

  typedef enum logic [3:0] {
    ST_CLR, ST_IDLE, ST_IDX, ST_IDX2, ST_RSA, ST_RSB, ST_RSC, ST_RSD, ST_RSE,
    ST_RD, ST_OP, ST_SUM, ST_CNT, ST_DONE
  } st_e;

  st_e                state_q;
  logic [MODE_W-1:0]  mode_q;
  logic [ADDR_W-1:0]  addr_q, len_q, base_q, start_q, st_q;
  logic [CNT_W-1:0]   pcount_q, n_q, free_q, first_q, last_q, pg_q;
  logic [WA_W-1:0]    wa_q;
  logic [ADDR_W:0]    diff_q, sum_q;
  logic [ADDR_W+1:0]  endr_q, lastd_q;
  logic [3:0]         bc_q [WORD_W/8];
  logic [6:0]         pc_q;
  logic [STAT_W-1:0]  status_q;
  logic               hit_q, resv_q, clr_op_q;
  logic               m_tvalid_q;
  logic [OUT_W-1:0]   m_tdata_q;

  logic [MODE_W-1:0]  in_mode;
  logic [ADDR_W-1:0]  in_addr, in_len;
  logic [CNT_W-1:0]   n_now, nm1;
  logic [WA_W-1:0]    first_wa, last_wa;
  logic [5:0]         lo_bit, hi_bit, pos;
  logic [WORD_W-1:0]  rmask, rdata, cand, onehot, newbits;
  logic               ram_we;
  logic [WORD_W-1:0]  ram_wdata;
  logic [PN_W-1:0]    idx_pn, first_pn;
  logic [ADDR_W+1-PB_SH:0] last_pn;
  logic [6:0]         pc_sum;
  logic [CNT_W-1:0]   used;
  logic [ADDR_W-1:0]  paddr;

  function automatic logic [3:0] pop8(input logic [7:0] b);
    logic [3:0] c;
    c = '0;
    for (int i = 0; i < 8; i++) begin
      c = c + 4'(b[i]);
    end
    return c;
  endfunction

  assign in_mode = s_axis_tdata[2:0];
  assign in_addr = s_axis_tdata[50:3];
  assign in_len  = s_axis_tdata[98:51];

  // managed page count: page_count clipped to MAX_FRAMES
  assign n_now = (CMP_W'(pcount_q) > CMP_W'(MAX_FRAMES)) ? CNT_W'(MAX_FRAMES) : pcount_q;
  assign nm1   = n_q - 1'b1;

  // pages of the current word that lie inside [first_q, last_q]
  assign first_wa = WA_W'(first_q >> 6);
  assign last_wa  = WA_W'(last_q >> 6);
  assign lo_bit   = (wa_q == first_wa) ? first_q[5:0] : 6'd0;
  assign hi_bit   = (wa_q == last_wa) ? last_q[5:0] : 6'd63;
  assign rmask    = ({WORD_W{1'b1}} << lo_bit) & ({WORD_W{1'b1}} >> (6'd63 - hi_bit));

  assign cand    = rmask & ~rdata;
  assign onehot  = cand & (~cand + 1'b1);
  assign newbits = rmask & ~rdata;

  always_comb begin
    pos = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (onehot[i]) begin
        pos = pos | 6'(i);
      end
    end
  end

  assign idx_pn   = diff_q[ADDR_W-1:PB_SH];
  assign first_pn = diff_q[ADDR_W-1:PB_SH];
  assign last_pn  = lastd_q[ADDR_W+1:PB_SH];

  always_comb begin
    pc_sum = '0;
    for (int i = 0; i < WORD_W/8; i++) begin
      pc_sum = pc_sum + 7'(bc_q[i]);
    end
  end

  assign used  = (pcount_q > free_q) ? pcount_q - free_q : '0;
  assign paddr = hit_q ? base_q + (ADDR_W'(pg_q) << PB_SH) : '0;

  // bitmap write port
  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = '0;
    if (state_q == ST_CLR) begin
      ram_we = 1'b1;
    end else if (state_q == ST_OP) begin
      unique case (mode_q)
        MODE_ALLOC: begin
          ram_we    = |cand;
          ram_wdata = rdata | onehot;
        end
        MODE_FREE: begin
          ram_we    = 1'b1;
          ram_wdata = rdata & ~(WORD_W'(1) << pg_q[5:0]);
        end
        MODE_RESERVE: begin
          ram_we    = 1'b1;
          ram_wdata = rdata | rmask;
        end
        default: begin
          ram_we = 1'b0;
        end
      endcase
    end
  end

  bpfa_ram #(
    .WIDTH(WORD_W),
    .DEPTH(MAP_WORDS)
  ) u_map (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(wa_q),
    .wdata_i(ram_wdata),
    .raddr_i(wa_q),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLR;
      mode_q     <= MODE_ALLOC;
      addr_q     <= '0;
      len_q      <= '0;
      base_q     <= '0;
      pcount_q   <= '0;
      n_q        <= '0;
      free_q     <= '0;
      first_q    <= '0;
      last_q     <= '0;
      pg_q       <= '0;
      wa_q       <= '0;
      diff_q     <= '0;
      sum_q      <= '0;
      endr_q     <= '0;
      lastd_q    <= '0;
      start_q    <= '0;
      st_q       <= '0;
      for (int i = 0; i < WORD_W/8; i++) begin
        bc_q[i] <= '0;
      end
      pc_q       <= '0;
      status_q   <= STAT_OK;
      hit_q      <= 1'b0;
      resv_q     <= 1'b0;
      clr_op_q   <= 1'b0;
      m_tvalid_q <= 1'b0;
      m_tdata_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_BASE_ADDR:  base_q   <= cfg_wdata_i;
          REG_PAGE_COUNT: pcount_q <= cfg_wdata_i[CNT_W-1:0];
          default:        base_q   <= base_q;
        endcase
      end

      if (m_tvalid_q && m_axis_tready && (state_q != ST_DONE)) begin
        m_tvalid_q <= 1'b0;
      end

      unique case (state_q)
        ST_CLR: begin
          if (wa_q == LAST_WA) begin
            state_q <= clr_op_q ? ST_DONE : ST_IDLE;
          end else begin
            wa_q <= wa_q + 1'b1;
          end
        end

        ST_IDLE: begin
          if (s_axis_tvalid) begin
            mode_q   <= in_mode;
            addr_q   <= in_addr;
            len_q    <= in_len;
            n_q      <= n_now;
            hit_q    <= 1'b0;
            resv_q   <= 1'b0;
            clr_op_q <= (in_mode == MODE_CLEAR);
            unique case (in_mode)
              MODE_ALLOC: begin
                if (n_now == '0) begin
                  status_q <= STAT_NOFREE;
                  state_q  <= ST_DONE;
                end else begin
                  status_q <= STAT_OK;
                  first_q  <= '0;
                  last_q   <= n_now - 1'b1;
                  wa_q     <= '0;
                  state_q  <= ST_RD;
                end
              end
              MODE_FREE, MODE_QUERY: begin
                status_q <= STAT_OK;
                state_q  <= ST_IDX;
              end
              MODE_RESERVE: begin
                status_q <= STAT_OK;
                state_q  <= ST_RSA;
              end
              MODE_CLEAR: begin
                status_q <= STAT_OK;
                free_q   <= n_now;
                wa_q     <= '0;
                state_q  <= ST_CLR;
              end
              default: begin
                status_q <= STAT_IGNORED;
                state_q  <= ST_DONE;
              end
            endcase
          end
        end

        // page index of addr for free and query
        ST_IDX: begin
          diff_q  <= {1'b0, addr_q} - {1'b0, base_q};
          state_q <= ST_IDX2;
        end

        ST_IDX2: begin
          if (diff_q[ADDR_W] || (ADDR_W'(idx_pn) >= ADDR_W'(n_q))) begin
            if (mode_q == MODE_FREE) begin
              status_q <= STAT_IGNORED;
            end
            state_q <= ST_DONE;
          end else begin
            pg_q    <= CNT_W'(idx_pn);
            wa_q    <= WA_W'(idx_pn >> 6);
            state_q <= ST_RD;
          end
        end

        // reserve: bound the range in pages
        ST_RSA: begin
          if (len_q == '0) begin
            state_q <= ST_DONE;
          end else if (n_q == '0) begin
            status_q <= STAT_INVALID;
            state_q  <= ST_DONE;
          end else begin
            sum_q   <= {1'b0, addr_q} + {1'b0, len_q};
            state_q <= ST_RSB;
          end
        end

        ST_RSB: begin
          endr_q  <= ({1'b0, sum_q} + (ADDR_W+2)'(PAGE_BYTES - 1))
                     & ~(ADDR_W+2)'(PAGE_BYTES - 1);
          start_q <= addr_q & ~OFF_MASK;
          state_q <= ST_RSC;
        end

        ST_RSC: begin
          if (endr_q <= {2'b00, base_q}) begin
            status_q <= STAT_INVALID;
            state_q  <= ST_DONE;
          end else begin
            st_q    <= (start_q < base_q) ? base_q : start_q;
            // end - 1 - base
            lastd_q <= endr_q + ~{2'b00, base_q};
            state_q <= ST_RSD;
          end
        end

        ST_RSD: begin
          diff_q  <= {1'b0, st_q} - {1'b0, base_q};
          state_q <= ST_RSE;
        end

        ST_RSE: begin
          if (ADDR_W'(first_pn) >= ADDR_W'(n_q)) begin
            status_q <= STAT_INVALID;
            state_q  <= ST_DONE;
          end else begin
            first_q <= CNT_W'(first_pn);
            last_q  <= ((ADDR_W+2)'(last_pn) >= (ADDR_W+2)'(nm1)) ? nm1 : CNT_W'(last_pn);
            wa_q    <= WA_W'(first_pn >> 6);
            state_q <= ST_RD;
          end
        end

        // bitmap word read issued at wa_q
        ST_RD: begin
          state_q <= ST_OP;
        end

        ST_OP: begin
          unique case (mode_q)
            MODE_ALLOC: begin
              if (|cand) begin
                pg_q    <= CNT_W'({wa_q, pos});
                hit_q   <= 1'b1;
                free_q  <= (free_q != '0) ? free_q - 1'b1 : free_q;
                state_q <= ST_DONE;
              end else if (wa_q == last_wa) begin
                status_q <= STAT_NOFREE;
                state_q  <= ST_DONE;
              end else begin
                wa_q    <= wa_q + 1'b1;
                state_q <= ST_RD;
              end
            end
            MODE_FREE: begin
              free_q  <= (free_q < n_q) ? free_q + 1'b1 : free_q;
              state_q <= ST_DONE;
            end
            MODE_QUERY: begin
              resv_q  <= rdata[pg_q[5:0]];
              state_q <= ST_DONE;
            end
            default: begin
              // reserve: count pages that go from free to used
              for (int i = 0; i < WORD_W/8; i++) begin
                bc_q[i] <= pop8(newbits[i*8 +: 8]);
              end
              state_q <= ST_SUM;
            end
          endcase
        end

        ST_SUM: begin
          pc_q    <= pc_sum;
          state_q <= ST_CNT;
        end

        ST_CNT: begin
          free_q <= (free_q > CNT_W'(pc_q)) ? free_q - CNT_W'(pc_q) : '0;
          if (wa_q == last_wa) begin
            state_q <= ST_DONE;
          end else begin
            wa_q    <= wa_q + 1'b1;
            state_q <= ST_RD;
          end
        end

        ST_DONE: begin
          if (!m_tvalid_q || m_axis_tready) begin
            m_tvalid_q <= 1'b1;
            m_tdata_q  <= {3'b000, used, free_q, resv_q, paddr, status_q};
            state_q    <= ST_IDLE;
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = m_tdata_q;

endmodule
